@@ design/hsv2rgb_pkg.sv @@
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// Shared types and constants of the HSV to RGB converter.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

   localparam int DEF_CHANNEL_BITS = 8;
   localparam int HUE_BITS         = 13;
   localparam int IN_BITS          = 8;
   localparam int OUT_BITS         = 8;
   localparam int DIST_BITS        = 10;
   localparam int HUE_SECTOR       = 960;
   // 960 = 15 << 6
   localparam int SECTOR_SHIFT     = 6;
   localparam int SECTOR_ODD       = 15;
   localparam int PIPE_STAGES      = 7;

   // named by the channel that ramps in the sector
   typedef enum logic [2:0] {
      SEC_GRN_UP,
      SEC_RED_DN,
      SEC_BLU_UP,
      SEC_GRN_DN,
      SEC_RED_UP,
      SEC_BLU_DN
   } sector_type;

   typedef struct packed {
      sector_type           sector;
      logic [DIST_BITS-1:0] ramp_dist;
      logic                 hue_err;
   } pix_ctl_type;

endpackage

@@ design/hsv2rgb_sector.sv @@
// ----------------------------------------------------------------------------
// hsv2rgb_sector
// First stage: clamps the channels, finds the hue sector and the ramp distance.
// ----------------------------------------------------------------------------
module hsv2rgb_sector #(
   parameter int CHANNEL_BITS = hsv2rgb_pkg::DEF_CHANNEL_BITS
) (
   input  logic                                  clock,
   input  logic                                  en,
   input  logic [hsv2rgb_pkg::HUE_BITS-1:0]      req_hue,
   input  logic [hsv2rgb_pkg::IN_BITS-1:0]       req_saturation,
   input  logic [hsv2rgb_pkg::IN_BITS-1:0]       req_brightness,
   output hsv2rgb_pkg::pix_ctl_type              ctl_ff,
   output logic [CHANNEL_BITS-1:0]               sat_ff,
   output logic [CHANNEL_BITS-1:0]               val_ff
);
   import hsv2rgb_pkg::*;

   localparam logic [CHANNEL_BITS-1:0] FULL = '1;
   localparam logic [HUE_BITS-1:0] H1 = HUE_BITS'(1 * HUE_SECTOR);
   localparam logic [HUE_BITS-1:0] H2 = HUE_BITS'(2 * HUE_SECTOR);
   localparam logic [HUE_BITS-1:0] H3 = HUE_BITS'(3 * HUE_SECTOR);
   localparam logic [HUE_BITS-1:0] H4 = HUE_BITS'(4 * HUE_SECTOR);
   localparam logic [HUE_BITS-1:0] H5 = HUE_BITS'(5 * HUE_SECTOR);
   localparam logic [HUE_BITS-1:0] H6 = HUE_BITS'(6 * HUE_SECTOR);

   pix_ctl_type             ctl_in;
   logic [CHANNEL_BITS-1:0] sat_in;
   logic [CHANNEL_BITS-1:0] val_in;

   always_comb begin
      // narrow channel widths saturate at full scale
      if (32'(req_saturation) > 32'(FULL)) begin
         sat_in = FULL;
      end else begin
         sat_in = CHANNEL_BITS'(req_saturation);
      end
      if (32'(req_brightness) > 32'(FULL)) begin
         val_in = FULL;
      end else begin
         val_in = CHANNEL_BITS'(req_brightness);
      end

      // boundary hue goes to the lower sector
      ctl_in.hue_err = 1'b0;
      if (req_hue <= H1) begin
         ctl_in.sector    = SEC_GRN_UP;
         ctl_in.ramp_dist = DIST_BITS'(req_hue);
      end else if (req_hue <= H2) begin
         ctl_in.sector    = SEC_RED_DN;
         ctl_in.ramp_dist = DIST_BITS'(H2 - req_hue);
      end else if (req_hue <= H3) begin
         ctl_in.sector    = SEC_BLU_UP;
         ctl_in.ramp_dist = DIST_BITS'(req_hue - H2);
      end else if (req_hue <= H4) begin
         ctl_in.sector    = SEC_GRN_DN;
         ctl_in.ramp_dist = DIST_BITS'(H4 - req_hue);
      end else if (req_hue <= H5) begin
         ctl_in.sector    = SEC_RED_UP;
         ctl_in.ramp_dist = DIST_BITS'(req_hue - H4);
      end else if (req_hue <= H6) begin
         ctl_in.sector    = SEC_BLU_DN;
         ctl_in.ramp_dist = DIST_BITS'(H6 - req_hue);
      end else begin
         ctl_in.sector    = SEC_GRN_UP;
         ctl_in.ramp_dist = '0;
         ctl_in.hue_err   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ctl_ff <= ctl_in;
         sat_ff <= sat_in;
         val_ff <= val_in;
      end
   end

endmodule

@@ design/hsv2rgb_chroma.sv @@
// ----------------------------------------------------------------------------
// hsv2rgb_chroma
// Three stages: sat * val, divide by full scale, min = val - chroma.
// ----------------------------------------------------------------------------
module hsv2rgb_chroma #(
   parameter int CHANNEL_BITS = hsv2rgb_pkg::DEF_CHANNEL_BITS
) (
   input  logic                     clock,
   input  logic [2:0]               en,
   input  hsv2rgb_pkg::pix_ctl_type ctl,
   input  logic [CHANNEL_BITS-1:0]  sat,
   input  logic [CHANNEL_BITS-1:0]  val,
   output hsv2rgb_pkg::pix_ctl_type ctl_ff,
   output logic [CHANNEL_BITS-1:0]  span_ff,
   output logic [CHANNEL_BITS-1:0]  min_ff,
   output logic [CHANNEL_BITS-1:0]  max_ff
);
   import hsv2rgb_pkg::*;

   localparam int W = CHANNEL_BITS;
   localparam logic [W-1:0] FULL = '1;

   // product stage
   logic [2*W-1:0] prod2_ff;
   logic [W-1:0]   val2_ff;
   pix_ctl_type    ctl2_ff;

   // estimate stage
   logic [2*W-1:0] prod3_ff;
   logic [W-1:0]   quo3_ff;
   logic [W-1:0]   val3_ff;
   pix_ctl_type    ctl3_ff;

   logic [2*W:0]   est_sum;
   logic [W-1:0]   quo3_in;
   logic [2*W-1:0] rem_full;
   logic [W:0]     rem;
   logic [W-1:0]   span_in;

   // x / (2^W - 1) ~ (x + x >> W) >> W, at most one short
   assign est_sum = (2*W+1)'(prod2_ff) + (2*W+1)'(prod2_ff >> W);
   assign quo3_in = est_sum[2*W-1:W];

   assign rem_full = prod3_ff + (2*W)'(quo3_ff) - {quo3_ff, {W{1'b0}}};
   assign rem      = rem_full[W:0];
   assign span_in  = quo3_ff + W'(rem >= (W+1)'(FULL));

   always_ff @(posedge clock) begin
      if (en[0]) begin
         prod2_ff <= (2*W)'(sat) * (2*W)'(val);
         val2_ff  <= val;
         ctl2_ff  <= ctl;
      end
      if (en[1]) begin
         prod3_ff <= prod2_ff;
         quo3_ff  <= quo3_in;
         val3_ff  <= val2_ff;
         ctl3_ff  <= ctl2_ff;
      end
      if (en[2]) begin
         span_ff <= span_in;
         min_ff  <= val3_ff - span_in;
         max_ff  <= val3_ff;
         ctl_ff  <= ctl3_ff;
      end
   end

endmodule

@@ design/hsv2rgb_ramp.sv @@
// ----------------------------------------------------------------------------
// hsv2rgb_ramp
// Three stages: span * dist, divide by 960, then pick the channels per sector.
// ----------------------------------------------------------------------------
module hsv2rgb_ramp #(
   parameter int CHANNEL_BITS = hsv2rgb_pkg::DEF_CHANNEL_BITS
) (
   input  logic                     clock,
   input  logic [2:0]               en,
   input  hsv2rgb_pkg::pix_ctl_type ctl,
   input  logic [CHANNEL_BITS-1:0]  span,
   input  logic [CHANNEL_BITS-1:0]  min_val,
   input  logic [CHANNEL_BITS-1:0]  max_val,
   output logic [CHANNEL_BITS-1:0]  red_ff,
   output logic [CHANNEL_BITS-1:0]  green_ff,
   output logic [CHANNEL_BITS-1:0]  blue_ff,
   output logic                     err_ff
);
   import hsv2rgb_pkg::*;

   localparam int W  = CHANNEL_BITS;
   localparam int YW = W + 4;
   localparam logic [W:0] RECIP = (W+1)'((1 << YW) / SECTOR_ODD);

   logic [W+DIST_BITS-1:0] mul5_ff;
   logic [W-1:0]           min5_ff;
   logic [W-1:0]           max5_ff;
   pix_ctl_type            ctl5_ff;

   logic [YW-1:0]          y6_ff;
   logic [YW+W:0]          rprod6_ff;
   logic [W-1:0]           min6_ff;
   logic [W-1:0]           max6_ff;
   pix_ctl_type            ctl6_ff;

   logic [YW-1:0]          y_in;
   logic [W-1:0]           quo0;
   logic [YW-1:0]          rem;
   logic [W-1:0]           ramp_val;
   logic [W-1:0]           red_in;
   logic [W-1:0]           green_in;
   logic [W-1:0]           blue_in;

   assign y_in = YW'(mul5_ff >> SECTOR_SHIFT);

   // floor reciprocal of 15 lands at most one short
   assign quo0     = rprod6_ff[YW +: W];
   assign rem      = y6_ff - ((YW'(quo0) << 4) - YW'(quo0));
   assign ramp_val = min6_ff + quo0 + W'(rem >= YW'(SECTOR_ODD));

   always_comb begin
      red_in   = max6_ff;
      green_in = min6_ff;
      blue_in  = min6_ff;
      case (ctl6_ff.sector)
         SEC_GRN_UP: begin
            red_in = max6_ff;  green_in = ramp_val; blue_in = min6_ff;
         end
         SEC_RED_DN: begin
            red_in = ramp_val; green_in = max6_ff;  blue_in = min6_ff;
         end
         SEC_BLU_UP: begin
            red_in = min6_ff;  green_in = max6_ff;  blue_in = ramp_val;
         end
         SEC_GRN_DN: begin
            red_in = min6_ff;  green_in = ramp_val; blue_in = max6_ff;
         end
         SEC_RED_UP: begin
            red_in = ramp_val; green_in = min6_ff;  blue_in = max6_ff;
         end
         SEC_BLU_DN: begin
            red_in = max6_ff;  green_in = min6_ff;  blue_in = ramp_val;
         end
         default: begin
            red_in = '0;       green_in = '0;       blue_in = '0;
         end
      endcase
      if (ctl6_ff.hue_err) begin
         red_in   = '0;
         green_in = '0;
         blue_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         mul5_ff <= (W+DIST_BITS)'(span) * (W+DIST_BITS)'(ctl.ramp_dist);
         min5_ff <= min_val;
         max5_ff <= max_val;
         ctl5_ff <= ctl;
      end
      if (en[1]) begin
         y6_ff     <= y_in;
         rprod6_ff <= (YW+W+1)'(y_in) * (YW+W+1)'(RECIP);
         min6_ff   <= min5_ff;
         max6_ff   <= max5_ff;
         ctl6_ff   <= ctl5_ff;
      end
      if (en[2]) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
         err_ff   <= ctl6_ff.hue_err;
      end
   end

endmodule

@@ design/hsv_to_rgb_converter.sv @@
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter
// HSV to RGB pixel converter, seven-stage pipeline.
// ----------------------------------------------------------------------------
// Takes one pixel beat per clock while req_stall is low; its color shows up on
// the result ports from the last stage, where rsp_stall holds it. The pipeline
// has seven register stages (sector decode, saturation product, full-scale
// divide estimate, divide correction and min, span times distance, reciprocal
// multiply for the divide by 960, correction and sector select); each stage
// moves on when the stage after it is empty or moving, so a stall on the
// result side fills empty stages first and only then stalls the request side.
// A hue above 5760 returns black with rsp_hue_error set.
module hsv_to_rgb_converter #(
   parameter int CHANNEL_BITS = hsv2rgb_pkg::DEF_CHANNEL_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [hsv2rgb_pkg::HUE_BITS-1:0]   req_hue,
   input  logic [hsv2rgb_pkg::IN_BITS-1:0]    req_saturation,
   input  logic [hsv2rgb_pkg::IN_BITS-1:0]    req_brightness,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [hsv2rgb_pkg::OUT_BITS-1:0]   rsp_red,
   output logic [hsv2rgb_pkg::OUT_BITS-1:0]   rsp_green,
   output logic [hsv2rgb_pkg::OUT_BITS-1:0]   rsp_blue,
   output logic                               rsp_hue_error
);
   import hsv2rgb_pkg::*;

   localparam int W = CHANNEL_BITS;

   logic [PIPE_STAGES-1:0] valid_ff;
   logic [PIPE_STAGES-1:0] valid_in;
   logic [PIPE_STAGES-1:0] en;

   pix_ctl_type  ctl1;
   logic [W-1:0] sat1;
   logic [W-1:0] val1;
   pix_ctl_type  ctl4;
   logic [W-1:0] span4;
   logic [W-1:0] min4;
   logic [W-1:0] max4;
   logic [W-1:0] red7;
   logic [W-1:0] green7;
   logic [W-1:0] blue7;
   logic         err7;

   always_comb begin
      en[PIPE_STAGES-1] = !valid_ff[PIPE_STAGES-1] || !rsp_stall;
      for (int i = PIPE_STAGES - 2; i >= 0; i--) begin
         en[i] = !valid_ff[i] || en[i+1];
      end
      valid_in[0] = en[0] ? req_valid : valid_ff[0];
      for (int i = 1; i < PIPE_STAGES; i++) begin
         valid_in[i] = en[i] ? valid_ff[i-1] : valid_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   hsv2rgb_sector #(.CHANNEL_BITS(CHANNEL_BITS)) u_sector (
      .clock          (clock),
      .en             (en[0]),
      .req_hue        (req_hue),
      .req_saturation (req_saturation),
      .req_brightness (req_brightness),
      .ctl_ff         (ctl1),
      .sat_ff         (sat1),
      .val_ff         (val1)
   );

   hsv2rgb_chroma #(.CHANNEL_BITS(CHANNEL_BITS)) u_chroma (
      .clock   (clock),
      .en      (en[3:1]),
      .ctl     (ctl1),
      .sat     (sat1),
      .val     (val1),
      .ctl_ff  (ctl4),
      .span_ff (span4),
      .min_ff  (min4),
      .max_ff  (max4)
   );

   hsv2rgb_ramp #(.CHANNEL_BITS(CHANNEL_BITS)) u_ramp (
      .clock    (clock),
      .en       (en[6:4]),
      .ctl      (ctl4),
      .span     (span4),
      .min_val  (min4),
      .max_val  (max4),
      .red_ff   (red7),
      .green_ff (green7),
      .blue_ff  (blue7),
      .err_ff   (err7)
   );

   assign req_stall     = !en[0];
   assign rsp_valid     = valid_ff[PIPE_STAGES-1];
   assign rsp_red       = OUT_BITS'(red7);
   assign rsp_green     = OUT_BITS'(green7);
   assign rsp_blue      = OUT_BITS'(blue7);
   assign rsp_hue_error = err7;

   // request side only backs up behind a stalled result
   a_no_spurious_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |-> !req_stall)
      else $error("request stalled while result side is free");

   a_last_stage_advances: assert property (@(posedge clock) disable iff (reset)
      valid_ff[PIPE_STAGES-2] && !rsp_stall |=> rsp_valid)
      else $error("beat lost entering output stage");

   a_error_is_black: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hue_error |->
         (rsp_red == '0) && (rsp_green == '0) && (rsp_blue == '0))
      else $error("hue error beat carries color");

endmodule
